// ===== sv/epda_pkg.sv =====
// Shared constants and types for the echo pulse distance averager.
// No dependencies; imported by epda_capture, epda_ring_accum and the top level.
package epda_pkg;

   // Result field width (distances and averages in cm)
   localparam int DIST_W = 11;
   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   // Capture field width on the request channel
   localparam int TICKS_W = 16;

   // Defaults for the top-level parameters
   localparam int RING_DEPTH_DEF   = 8;
   localparam int TICKS_PER_CM_DEF = 58;
   localparam int TIMER_BITS_DEF   = 16;

   // Per-item control that rides along the pipeline
   typedef struct packed {
      logic fall;   // falling-edge capture: distance is measured
      logic busy;   // measuring flag after this item
      logic full;   // average-valid flag after this item
   } ctrl_type;

endpackage

// ===== sv/epda_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module epda_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/epda_capture.sv =====
// Edge capture stage: rise time, measuring flag, ring slot and fill flag,
// per-entry valid bits, pulse width clamp and the first pipeline register.
// Depends on epda_pkg.
module epda_capture #(
   parameter int RING_DEPTH   = 8,
   parameter int TICKS_PER_CM = 58,
   parameter int TIMER_BITS   = 16
) (
   input  logic                                           clock,
   input  logic                                           reset,
   // request transfer
   input  logic                                           take,
   input  logic                                           echo_level,
   input  logic [epda_pkg::TICKS_W-1:0]                   capture_ticks,
   // first stage hands its item on
   input  logic                                           p1_take,
   // ring write from the update stage
   input  logic                                           wr_en,
   input  logic [$clog2(RING_DEPTH)-1:0]                  wr_slot,
   input  logic [epda_pkg::DIST_W-1:0]                    wr_data,
   // ring read
   output logic                                           rd_en,
   output logic [$clog2(RING_DEPTH)-1:0]                  rd_addr,
   // first stage
   output logic                                           p1_valid,
   output epda_pkg::ctrl_type                             p1_ctrl,
   output logic [epda_pkg::DIST_W+$clog2(TICKS_PER_CM)-1:0] p1_x,
   output logic                                           p1_sat,
   output logic [$clog2(RING_DEPTH)-1:0]                  p1_slot,
   output logic                                           p1_hit,
   output logic [epda_pkg::DIST_W-1:0]                    p1_fwd,
   output logic                                           p1_evld
);
   import epda_pkg::*;

   localparam int SLOT_W = $clog2(RING_DEPTH);
   localparam int DIV_L  = $clog2(TICKS_PER_CM);
   localparam int X_W    = DIST_W + DIV_L;
   localparam int CMP_W  = ((TIMER_BITS > X_W) ? TIMER_BITS : X_W) + 1;
   localparam longint unsigned SAT_LIMIT = (64'd1 << DIST_W) * 64'(TICKS_PER_CM);
   localparam int HALF   = RING_DEPTH / 2;

   logic [TIMER_BITS-1:0] rise_ff, rise_in;
   logic                  busy_ff, busy_in;
   logic                  full_ff, full_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [RING_DEPTH-1:0] evld_ff;

   logic                  p1_valid_ff, p1_valid_in;
   ctrl_type              p1_ctrl_ff;
   logic [X_W-1:0]        p1_x_ff;
   logic                  p1_sat_ff;
   logic [SLOT_W-1:0]     p1_slot_ff;
   logic                  p1_hit_ff;
   logic [DIST_W-1:0]     p1_fwd_ff;
   logic                  p1_evld_ff;

   logic [TIMER_BITS-1:0] ticks;
   logic [TIMER_BITS-1:0] diff;
   logic                  sat;
   logic [SLOT_W:0]       slot_inc;
   logic                  hit;

   assign ticks    = TIMER_BITS'(capture_ticks);
   assign diff     = ticks - rise_ff;
   assign sat      = CMP_W'(diff) >= CMP_W'(SAT_LIMIT);
   assign slot_inc = {1'b0, slot_ff} + 1'b1;
   // write landing on the slot being read this cycle
   assign hit      = wr_en && (wr_slot == slot_ff);

   always_comb begin
      rise_in = rise_ff;
      busy_in = busy_ff;
      full_in = full_ff;
      slot_in = slot_ff;
      if (take) begin
         if (echo_level) begin
            rise_in = ticks;
            busy_in = 1'b1;
         end else begin
            busy_in = 1'b0;
            slot_in = slot_inc[SLOT_W-1:0];
            if (slot_inc == (SLOT_W+1)'(HALF)) begin
               full_in = 1'b0;
            end
            if (slot_inc == (SLOT_W+1)'(RING_DEPTH)) begin
               slot_in = '0;
               full_in = 1'b1;
            end
         end
      end
   end

   always_comb begin
      p1_valid_in = p1_valid_ff;
      if (take) begin
         p1_valid_in = 1'b1;
      end else if (p1_take) begin
         p1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rise_ff     <= '0;
         busy_ff     <= 1'b0;
         full_ff     <= 1'b0;
         slot_ff     <= '0;
         evld_ff     <= '0;
         p1_valid_ff <= 1'b0;
      end else begin
         rise_ff     <= rise_in;
         busy_ff     <= busy_in;
         full_ff     <= full_in;
         slot_ff     <= slot_in;
         p1_valid_ff <= p1_valid_in;
         if (wr_en) begin
            evld_ff[wr_slot] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         p1_ctrl_ff.fall <= ~echo_level;
         p1_ctrl_ff.busy <= busy_in;
         p1_ctrl_ff.full <= full_in;
         p1_x_ff         <= X_W'(diff);
         p1_sat_ff       <= sat;
         p1_slot_ff      <= slot_ff;
         p1_hit_ff       <= hit;
         p1_fwd_ff       <= wr_data;
         p1_evld_ff      <= evld_ff[slot_ff];
      end
   end

   assign rd_en    = take;
   assign rd_addr  = slot_ff;
   assign p1_valid = p1_valid_ff;
   assign p1_ctrl  = p1_ctrl_ff;
   assign p1_x     = p1_x_ff;
   assign p1_sat   = p1_sat_ff;
   assign p1_slot  = p1_slot_ff;
   assign p1_hit   = p1_hit_ff;
   assign p1_fwd   = p1_fwd_ff;
   assign p1_evld  = p1_evld_ff;

endmodule

// ===== sv/epda_ring_accum.sv =====
// Distance scaling, ring read-modify-write and running sum (stages 2 and 3).
// Depends on epda_pkg; drives the write port of the ring RAM.
module epda_ring_accum #(
   parameter int RING_DEPTH   = 8,
   parameter int TICKS_PER_CM = 58
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             p1_valid,
   input  epda_pkg::ctrl_type                               p1_ctrl,
   input  logic [epda_pkg::DIST_W+$clog2(TICKS_PER_CM)-1:0] p1_x,
   input  logic                                             p1_sat,
   input  logic [$clog2(RING_DEPTH)-1:0]                    p1_slot,
   input  logic                                             p1_hit,
   input  logic [epda_pkg::DIST_W-1:0]                      p1_fwd,
   input  logic                                             p1_evld,
   input  logic [epda_pkg::DIST_W-1:0]                      rd_data,
   input  logic                                             out_ready,
   output logic                                             p1_take,
   output logic                                             wr_en,
   output logic [$clog2(RING_DEPTH)-1:0]                    wr_slot,
   output logic [epda_pkg::DIST_W-1:0]                      wr_data,
   output logic                                             p3_valid,
   output epda_pkg::ctrl_type                               p3_ctrl,
   output logic [epda_pkg::DIST_W-1:0]                      last_dist,
   output logic [epda_pkg::DIST_W+$clog2(RING_DEPTH)-1:0]   ring_sum
);
   import epda_pkg::*;

   localparam int SLOT_W = $clog2(RING_DEPTH);
   localparam int DIV_L  = $clog2(TICKS_PER_CM);
   localparam int X_W    = DIST_W + DIV_L;
   localparam int DIV_S  = X_W + DIV_L;
   localparam int MUL_W  = X_W + 2;
   localparam int P_W    = X_W + MUL_W;
   localparam int SUM_W  = DIST_W + $clog2(RING_DEPTH);
   // ceil(2^DIV_S / TICKS_PER_CM): exact quotient for every unclamped width
   localparam logic [MUL_W-1:0] DIV_MUL =
      MUL_W'(((64'd1 << DIV_S) + 64'(TICKS_PER_CM) - 64'd1) / 64'(TICKS_PER_CM));
   localparam longint unsigned SUM_MAX = 64'(RING_DEPTH) * 64'(DIST_MAX);

   logic              p2_valid_ff, p2_valid_in;
   ctrl_type          p2_ctrl_ff;
   logic [P_W-1:0]    p2_prod_ff;
   logic              p2_sat_ff;
   logic [SLOT_W-1:0] p2_slot_ff;
   logic [DIST_W-1:0] p2_old_ff;

   logic              p3_valid_ff, p3_valid_in;
   ctrl_type          p3_ctrl_ff;
   logic [DIST_W-1:0] last_ff, last_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;

   logic              p3_take, p3_ready, p2_take, p2_ready;
   logic [DIST_W-1:0] dist_cm;
   logic [DIST_W-1:0] old_val;

   assign p3_take  = p3_valid_ff && out_ready;
   assign p3_ready = !p3_valid_ff || p3_take;
   assign p2_take  = p2_valid_ff && p3_ready;
   assign p2_ready = !p2_valid_ff || p2_take;
   assign p1_take  = p1_valid && p2_ready;

   // a same-cycle write to the read slot wins over the RAM data;
   // never-written entries read as zero
   assign old_val = p1_hit ? p1_fwd : (p1_evld ? rd_data : '0);

   assign dist_cm = p2_sat_ff ? DIST_MAX : p2_prod_ff[DIV_S +: DIST_W];
   assign wr_en   = p2_take && p2_ctrl_ff.fall;
   assign wr_slot = p2_slot_ff;
   assign wr_data = dist_cm;

   always_comb begin
      p2_valid_in = p2_valid_ff;
      if (p1_take) begin
         p2_valid_in = 1'b1;
      end else if (p2_take) begin
         p2_valid_in = 1'b0;
      end
      p3_valid_in = p3_valid_ff;
      if (p2_take) begin
         p3_valid_in = 1'b1;
      end else if (p3_take) begin
         p3_valid_in = 1'b0;
      end
      last_in = last_ff;
      sum_in  = sum_ff;
      if (wr_en) begin
         last_in = dist_cm;
         sum_in  = sum_ff - SUM_W'(p2_old_ff) + SUM_W'(dist_cm);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
         last_ff     <= '0;
         sum_ff      <= '0;
      end else begin
         p2_valid_ff <= p2_valid_in;
         p3_valid_ff <= p3_valid_in;
         last_ff     <= last_in;
         sum_ff      <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (p1_take) begin
         p2_ctrl_ff <= p1_ctrl;
         p2_prod_ff <= P_W'(p1_x) * P_W'(DIV_MUL);
         p2_sat_ff  <= p1_sat;
         p2_slot_ff <= p1_slot;
         p2_old_ff  <= old_val;
      end
      if (p2_take) begin
         p3_ctrl_ff <= p2_ctrl_ff;
      end
   end

   assign p3_valid  = p3_valid_ff;
   assign p3_ctrl   = p3_ctrl_ff;
   assign last_dist = last_ff;
   assign ring_sum  = sum_ff;

   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      64'(sum_ff) <= SUM_MAX)
      else $error("ring sum exceeds a full ring of maximum distances");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (32'(wr_slot) < RING_DEPTH))
      else $error("ring write beyond last slot");

   a_p3_holds: assert property (@(posedge clock) disable iff (reset)
      (p3_valid_ff && !out_ready) |=> (p3_valid_ff && $stable(sum_ff)))
      else $error("running sum moved while its result was held");

endmodule

// ===== sv/echo_pulse_distance_averager.sv =====
// Echo pulse distance averager: takes one echo-edge transfer per cycle and
// presents one result per input, passing it through the capture register,
// stages 2 and 3 and the result register. Sustained rate is one item per
// clock; the input stalls only when all three stages are full behind a
// stalled result. The ring of recent distances
// sits in a RAM with one write port, read at capture
// and written two stages later, with a bypass for a write hitting the slot
// being read. The ring clears at reset through per-entry valid bits, so no
// clearing pass is needed. Distance is (falling - rising ticks) mod
// 2^TIMER_BITS divided by TICKS_PER_CM; the average is the ring sum divided
// by RING_DEPTH, both by reciprocal multiply, saturating at 2047.
// Depends on epda_pkg, epda_capture, epda_ring_accum and epda_ram.
module echo_pulse_distance_averager #(
   parameter int RING_DEPTH   = epda_pkg::RING_DEPTH_DEF,
   parameter int TICKS_PER_CM = epda_pkg::TICKS_PER_CM_DEF,
   parameter int TIMER_BITS   = epda_pkg::TIMER_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_echo_level,
   input  logic [epda_pkg::TICKS_W-1:0] req_capture_ticks,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [epda_pkg::DIST_W-1:0]  rsp_distance_cm,
   output logic [epda_pkg::DIST_W-1:0]  rsp_avg_cm,
   output logic                         rsp_avg_valid,
   output logic                         rsp_measuring,
   output logic                         rsp_clear_timer
);
   import epda_pkg::*;

   localparam int SLOT_W = $clog2(RING_DEPTH);
   localparam int X_W    = DIST_W + $clog2(TICKS_PER_CM);
   localparam int SUM_W  = DIST_W + $clog2(RING_DEPTH);
   localparam int AVG_L  = $clog2(RING_DEPTH);
   localparam int AVG_S  = SUM_W + AVG_L;
   localparam int AVG_MW = SUM_W + 2;
   localparam int AVG_PW = SUM_W + AVG_MW;
   localparam logic [AVG_MW-1:0] AVG_MUL =
      AVG_MW'(((64'd1 << AVG_S) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH));

   logic              take;
   logic              p1_ready;
   logic              out_ready;
   logic              p3_take;

   logic              rd_en;
   logic [SLOT_W-1:0] rd_addr;
   logic [DIST_W-1:0] rd_data;
   logic              wr_en;
   logic [SLOT_W-1:0] wr_slot;
   logic [DIST_W-1:0] wr_data;

   logic              p1_valid;
   ctrl_type          p1_ctrl;
   logic [X_W-1:0]    p1_x;
   logic              p1_sat;
   logic [SLOT_W-1:0] p1_slot;
   logic              p1_hit;
   logic [DIST_W-1:0] p1_fwd;
   logic              p1_evld;
   logic              p1_take;

   logic              p3_valid;
   ctrl_type          p3_ctrl;
   logic [DIST_W-1:0] last_dist;
   logic [SUM_W-1:0]  ring_sum;
   logic [AVG_PW-1:0] avg_prod;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0] rsp_distance_cm_ff;
   logic [DIST_W-1:0] rsp_avg_cm_ff;
   logic              rsp_avg_valid_ff;
   logic              rsp_measuring_ff;
   logic              rsp_clear_timer_ff;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign p3_take   = p3_valid && out_ready;
   assign p1_ready  = !p1_valid || p1_take;
   assign req_stall = !p1_ready;
   assign take      = req_valid && p1_ready;

   epda_capture #(
      .RING_DEPTH   (RING_DEPTH),
      .TICKS_PER_CM (TICKS_PER_CM),
      .TIMER_BITS   (TIMER_BITS)
   ) u_capture (
      .clock         (clock),
      .reset         (reset),
      .take          (take),
      .echo_level    (req_echo_level),
      .capture_ticks (req_capture_ticks),
      .p1_take       (p1_take),
      .wr_en         (wr_en),
      .wr_slot       (wr_slot),
      .wr_data       (wr_data),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .p1_valid      (p1_valid),
      .p1_ctrl       (p1_ctrl),
      .p1_x          (p1_x),
      .p1_sat        (p1_sat),
      .p1_slot       (p1_slot),
      .p1_hit        (p1_hit),
      .p1_fwd        (p1_fwd),
      .p1_evld       (p1_evld)
   );

   epda_ram #(
      .WIDTH (DIST_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_slot),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   epda_ring_accum #(
      .RING_DEPTH   (RING_DEPTH),
      .TICKS_PER_CM (TICKS_PER_CM)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .p1_valid  (p1_valid),
      .p1_ctrl   (p1_ctrl),
      .p1_x      (p1_x),
      .p1_sat    (p1_sat),
      .p1_slot   (p1_slot),
      .p1_hit    (p1_hit),
      .p1_fwd    (p1_fwd),
      .p1_evld   (p1_evld),
      .rd_data   (rd_data),
      .out_ready (out_ready),
      .p1_take   (p1_take),
      .wr_en     (wr_en),
      .wr_slot   (wr_slot),
      .wr_data   (wr_data),
      .p3_valid  (p3_valid),
      .p3_ctrl   (p3_ctrl),
      .last_dist (last_dist),
      .ring_sum  (ring_sum)
   );

   // sum / RING_DEPTH via reciprocal; always below 2048
   assign avg_prod = AVG_PW'(ring_sum) * AVG_PW'(AVG_MUL);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (p3_take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (p3_take) begin
         rsp_distance_cm_ff <= last_dist;
         rsp_avg_cm_ff      <= avg_prod[AVG_S +: DIST_W];
         rsp_avg_valid_ff   <= p3_ctrl.full;
         rsp_measuring_ff   <= p3_ctrl.busy;
         rsp_clear_timer_ff <= p3_ctrl.fall;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_distance_cm = rsp_distance_cm_ff;
   assign rsp_avg_cm      = rsp_avg_cm_ff;
   assign rsp_avg_valid   = rsp_avg_valid_ff;
   assign rsp_measuring   = rsp_measuring_ff;
   assign rsp_clear_timer = rsp_clear_timer_ff;

   // input only backs up once every stage is full behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid_ff && rsp_stall))
      else $error("request stalled with room in the pipeline");

   a_edge_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_clear_timer_ff) |-> !rsp_measuring_ff)
      else $error("falling-edge result still flagged as measuring");

   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid_ff)
      else $error("result presented right after reset");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for echo_pulse_distance_averager: directed captures, then
// random rise/fall sequences under random stalls, checked against an in-bench model.
// Depends on epda_pkg and the echo_pulse_distance_averager RTL.
`timescale 1ns / 1ps

module testbench;
   import epda_pkg::*;

   localparam logic EDGE_RISE = 1'b1;
   localparam logic EDGE_FALL = 1'b0;
   localparam int DIR_ROWS = 22;

   typedef struct packed {
      logic [DIST_W-1:0] dist_cm;
      logic [DIST_W-1:0] avg;
      logic              valid;
      logic              meas;
      logic              clr;
   } echo_result_type;

   typedef struct {
      logic                level;
      logic [TICKS_W-1:0]  ticks;
      bit                  typed;
      echo_result_type     res;
   } edge_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_echo_level = 1'b0;
   logic [TICKS_W-1:0]  req_capture_ticks = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [DIST_W-1:0]   rsp_distance_cm;
   logic [DIST_W-1:0]   rsp_avg_cm;
   logic                rsp_avg_valid;
   logic                rsp_measuring;
   logic                rsp_clear_timer;

   // Model state of the block
   logic [31:0]         rise_ticks;
   logic [DIST_W-1:0]   last_cm;
   logic [DIST_W-1:0]   ring_cm [RING_DEPTH_DEF];
   int                  ring_pos;
   int                  ring_total;
   logic                ring_full;
   logic                in_pulse;

   echo_result_type     pending_results [$];
   edge_row_type        dir_rows [DIR_ROWS];

   int                  errors = 0;
   int                  results_checked = 0;
   int                  rise_count = 0;
   int                  fall_count = 0;
   int                  wrap_count = 0;
   int                  send_idle_pct = 0;
   int                  recv_idle_pct = 0;
   int                  holds_asked = 0;
   int                  holds_done = 0;
   int                  hold_left = 0;

   echo_pulse_distance_averager DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_echo_level    (req_echo_level),
      .req_capture_ticks (req_capture_ticks),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_distance_cm   (rsp_distance_cm),
      .rsp_avg_cm        (rsp_avg_cm),
      .rsp_avg_valid     (rsp_avg_valid),
      .rsp_measuring     (rsp_measuring),
      .rsp_clear_timer   (rsp_clear_timer)
   );

   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic void clear_echo_model();
      rise_ticks = '0;
      last_cm    = '0;
      for (int i = 0; i < RING_DEPTH_DEF; i++) ring_cm[i] = '0;
      ring_pos   = 0;
      ring_total = 0;
      ring_full  = 1'b0;
      in_pulse   = 1'b0;
   endfunction

   // Advances the model by one capture and returns the result it produces
   function automatic echo_result_type predict_echo(input logic lvl,
                                                    input logic [TICKS_W-1:0] tk);
      logic [31:0]     mask;
      logic [31:0]     span;
      int unsigned     cm;
      int unsigned     mean;
      echo_result_type res;
      mask = 32'((64'd1 << TIMER_BITS_DEF) - 1);
      res.clr = 1'b0;
      if (lvl == EDGE_RISE) begin
         rise_ticks = 32'(tk) & mask;
         in_pulse   = 1'b1;
         rise_count++;
      end else begin
         span = (32'(tk) - rise_ticks) & mask;
         cm   = span / TICKS_PER_CM_DEF;
         if (cm > 32'(DIST_MAX)) cm = 32'(DIST_MAX);
         last_cm    = DIST_W'(cm);
         ring_total = ring_total - int'(ring_cm[ring_pos]) + int'(cm);
         ring_cm[ring_pos] = DIST_W'(cm);
         ring_pos++;
         if (ring_pos == RING_DEPTH_DEF / 2) ring_full = 1'b0;
         if (ring_pos >= RING_DEPTH_DEF) begin
            ring_pos  = 0;
            ring_full = 1'b1;
            wrap_count++;
         end
         in_pulse = 1'b0;
         res.clr  = 1'b1;
         fall_count++;
      end
      mean = 32'(ring_total) / RING_DEPTH_DEF;
      if (mean > 32'(DIST_MAX)) mean = 32'(DIST_MAX);
      res.dist_cm = last_cm;
      res.avg     = DIST_W'(mean);
      res.valid   = ring_full;
      res.meas    = in_pulse;
      return res;
   endfunction

   task automatic drive_edge(input logic lvl, input logic [TICKS_W-1:0] tk, input bit typed,
                             input echo_result_type typed_res);
      echo_result_type pred;
      bit              taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_echo_level    <= lvl;
      req_capture_ticks <= tk;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         if (taken) begin
            pred = predict_echo(lvl, tk);
            pending_results.push_back(typed ? typed_res : pred);
         end
         @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Mostly complete rise/fall pulses with random timing, some stray edges
   task automatic run_random(input int n_items);
      int                 sent;
      int                 pick;
      logic [TICKS_W-1:0] t0;
      int unsigned        delta;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         t0   = TICKS_W'($urandom);
         if (pick < 80) begin
            case ($urandom_range(3))
               0:       delta = $urandom_range(TICKS_PER_CM_DEF - 1);
               1:       delta = $urandom_range(TICKS_PER_CM_DEF * 100);
               2:       delta = $urandom_range(65535);
               default: delta = 65535 - $urandom_range(200);
            endcase
            drive_edge(EDGE_RISE, t0, 1'b0, '0);
            drive_edge(EDGE_FALL, t0 + TICKS_W'(delta), 1'b0, '0);
            sent += 2;
         end else begin
            drive_edge(pick < 90 ? EDGE_RISE : EDGE_FALL, t0, 1'b0, '0);
            sent++;
         end
      end
   endtask

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   // Receiver: random stalls, plus a long hold-off when the stimulus asks for one
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (holds_done != holds_asked) begin
         holds_done = holds_asked;
         hold_left  = 200;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Outputs are stable at the falling edge; a transfer here completes at the next rise
   always @(negedge clock) begin
      echo_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("result transfer with no capture outstanding");
            errors++;
         end else begin
            want = pending_results.pop_front();
            check_field("distance_cm", 32'(want.dist_cm), 32'(rsp_distance_cm));
            check_field("avg_cm", 32'(want.avg), 32'(rsp_avg_cm));
            check_field("avg_valid", 32'(want.valid), 32'(rsp_avg_valid));
            check_field("measuring", 32'(want.meas), 32'(rsp_measuring));
            check_field("clear_timer", 32'(want.clr), 32'(rsp_clear_timer));
            results_checked++;
         end
      end
   end

   initial begin
      dir_rows = '{
         // falling edge straight out of reset measures from time zero
         '{EDGE_FALL, 16'h0000, 1'b1, '{11'd0, 11'd0, 1'b0, 1'b0, 1'b1}},
         '{EDGE_RISE, 16'h0000, 1'b1, '{11'd0, 11'd0, 1'b0, 1'b1, 1'b0}},
         '{EDGE_FALL, 16'hFFFF, 1'b1, '{11'd1129, 11'd141, 1'b0, 1'b0, 1'b1}},
         '{EDGE_RISE, 16'hFFFF, 1'b1, '{11'd1129, 11'd141, 1'b0, 1'b1, 1'b0}},
         '{EDGE_RISE, 16'd100,  1'b0, '0},   // second rise overwrites start time
         '{EDGE_FALL, 16'd99,   1'b0, '0},   // timer wrapped between edges
         '{EDGE_RISE, 16'hAAAA, 1'b0, '0},
         '{EDGE_FALL, 16'hAAE3, 1'b0, '0},   // one tick short of a centimeter
         '{EDGE_RISE, 16'h5555, 1'b0, '0},
         '{EDGE_FALL, 16'h558F, 1'b0, '0},
         '{EDGE_RISE, 16'h1234, 1'b0, '0},
         '{EDGE_FALL, 16'h2ADC, 1'b0, '0},
         '{EDGE_FALL, 16'h4384, 1'b0, '0},   // no rise in between: reuses old start
         '{EDGE_RISE, 16'h8000, 1'b0, '0},
         '{EDGE_FALL, 16'hFFFF, 1'b0, '0},   // ring wraps, average becomes valid
         '{EDGE_RISE, 16'h0000, 1'b0, '0},
         '{EDGE_FALL, 16'd1000, 1'b0, '0},
         '{EDGE_FALL, 16'd2000, 1'b0, '0},
         '{EDGE_FALL, 16'd3000, 1'b0, '0},
         '{EDGE_FALL, 16'd4000, 1'b0, '0},   // half the ring: valid drops
         '{EDGE_RISE, 16'h7FFF, 1'b0, '0},
         '{EDGE_FALL, 16'h8000, 1'b0, '0}
      };
      clear_echo_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 29;
      recv_idle_pct = 50;
      for (int i = 0; i < DIR_ROWS; i++)
         drive_edge(dir_rows[i].level, dir_rows[i].ticks, dir_rows[i].typed, dir_rows[i].res);
      run_random(330);
      wait_drained();

      send_idle_pct = 50;
      recv_idle_pct = 29;
      run_random(350);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      holds_asked++;
      run_random(350);
      wait_drained();

      repeat (20) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d results never arrived", pending_results.size());
         errors++;
      end
      $display("Checked %0d results from %0d rising and %0d falling captures.",
               results_checked, rise_count, fall_count);
      $display("The averaging ring wrapped %0d times, with random and long output stalls.",
               wrap_count);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
